@@ rtl/pgrep_pkg.sv @@
// Shared types and constants for the page replacement block.
// Used by pgrep_cell and page_replacement_fifo_lru_top; depends on nothing.
`timescale 1ns / 1ps

package pgrep_pkg;

    localparam int ADDR_W     = 31;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PAGE_W     = 19;

    localparam int FRAMES_DEFAULT = 16;

    localparam int FIU_W = 5;
    localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'b1;

    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_LRU  = 1'b1;

    typedef logic [PAGE_W-1:0] page_t;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic step;    // an item is being resolved this cycle
        logic lru;     // LRU policy selected
        logic in_lim;  // this cell lies inside the frames in use
    } cell_ctrl_t;

endpackage

@@ rtl/page_replacement_fifo_lru_top.sv @@
// Top level of the FIFO / LRU page replacement unit: a row of frame cells,
// an input register, an output register and the configuration registers.
// Depends on pgrep_pkg and pgrep_cell.
`timescale 1ns / 1ps

// Usage
// Each input item carries one virtual byte address on s_virtual_address. The
// page number is the address divided by the page size. The resident pages sit
// in a row of frame cells, newest (or most recently used) at the front. Every
// item yields exactly one result item on the m_ channel: hit, evicted, the
// evicted page (zero when none) and the page number of the access.
// An accepted item sits in the input register while all cells compare in
// parallel and shift as the policy requires, and the output register loads
// the result at the same edge that updates the cells; while the receiver
// stalls, the item waits in the input register. Throughput is one item per
// cycle while the receiver does not stall, as the row compare is combinational.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes replace_mode
// (index 0, 0 FIFO, 1 LRU) and frames_in_use (index 1, 0 acts as 1, values
// above FRAMES act as FRAMES). Write it only while the block is idle.
// Reset empties every frame, selects FIFO mode and sixteen frames in use.
// When the receiver stalls, the result holds in the output register and the
// input register takes one more item only while it is empty; then s_ready drops.
module page_replacement_fifo_lru_top
    import pgrep_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ADDR_W-1:0]     s_virtual_address,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_hit,
    output logic                  m_evicted,
    output logic [PAGE_W-1:0]     m_evicted_page,
    output logic [PAGE_W-1:0]     m_page_number
);

    // The frame count compare must hold both the register and FRAMES itself.
    localparam int FR_W  = $clog2(FRAMES + 1);
    localparam int CNT_W = (FR_W > FIU_W) ? FR_W : FIU_W;

    // Configuration registers.
    logic             replace_mode_reg;
    logic [FIU_W-1:0] frames_in_use_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            replace_mode_reg  <= MODE_FIFO;
            frames_in_use_reg <= FIU_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_REPLACE_MODE:  replace_mode_reg  <= cfg_wdata[0];
                REG_FRAMES_IN_USE: frames_in_use_reg <= cfg_wdata[FIU_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective number of frames, clamped to the range 1 to FRAMES.
    logic [CNT_W-1:0] fiu_ext;
    logic [CNT_W-1:0] lim;

    assign fiu_ext = CNT_W'(frames_in_use_reg);

    always_comb begin
        if (fiu_ext == '0) begin
            lim = CNT_W'(1);
        end else if (fiu_ext > CNT_W'(FRAMES)) begin
            lim = CNT_W'(FRAMES);
        end else begin
            lim = fiu_ext;
        end
    end

    // Input register: holds the page number of the item being resolved.
    logic  in_valid_reg;
    page_t in_page_reg;
    logic  m_valid_reg;
    logic  out_free;
    logic  fire;

    assign out_free = !m_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_page_reg <= PAGE_W'(s_virtual_address >> PAGE_SHIFT);
        end
    end

    // Row of frame cells. Cell 0 takes the new page from the left; the match
    // chain runs from the back of the row toward the front.
    cell_ctrl_t ctrl_vec   [FRAMES];
    page_t      page_vec   [FRAMES];
    logic [FRAMES-1:0] valid_vec;
    logic [FRAMES-1:0] match_vec;
    logic [FRAMES-1:0] match_ge_vec;
    logic [FRAMES-1:0] last_vec;
    logic              hit;

    assign hit = match_ge_vec[0];

    genvar gi;
    generate
        for (gi = 0; gi < FRAMES; gi++) begin : g_cell
            page_t left_page;
            logic  left_valid;
            logic  match_right;

            assign ctrl_vec[gi].step   = fire;
            assign ctrl_vec[gi].lru    = (replace_mode_reg == MODE_LRU);
            assign ctrl_vec[gi].in_lim = CNT_W'(gi) < lim;
            assign last_vec[gi]        = CNT_W'(gi + 1) == lim;

            if (gi == 0) begin : g_front
                assign left_page  = in_page_reg;
                assign left_valid = 1'b1;
            end else begin : g_inner
                assign left_page  = page_vec[gi-1];
                assign left_valid = valid_vec[gi-1];
            end

            if (gi == FRAMES - 1) begin : g_back
                assign match_right = 1'b0;
            end else begin : g_chain
                assign match_right = match_ge_vec[gi+1];
            end

            pgrep_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl_vec[gi]),
                .hit_in      (hit),
                .cmp_page    (in_page_reg),
                .left_page   (left_page),
                .left_valid  (left_valid),
                .match_right (match_right),
                .match       (match_vec[gi]),
                .match_ge    (match_ge_vec[gi]),
                .page        (page_vec[gi]),
                .valid       (valid_vec[gi])
            );
        end
    endgenerate

    // The last frame in use is the one pushed out on a miss. Exactly one
    // cell is marked last, so an AND-OR over the row selects it.
    logic  last_valid;
    page_t last_page;

    always_comb begin
        last_valid = 1'b0;
        last_page  = '0;
        for (int i = 0; i < FRAMES; i++) begin
            last_valid = last_valid | (last_vec[i] & valid_vec[i]);
            last_page  = last_page | (page_vec[i] & {PAGE_W{last_vec[i]}});
        end
    end

    // Output register.
    logic  m_hit_reg;
    logic  m_evicted_reg;
    page_t m_evicted_page_reg;
    page_t m_page_number_reg;
    logic  evict;

    assign evict = !hit && last_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= fire;
        end
        if (fire) begin
            m_hit_reg          <= hit;
            m_evicted_reg      <= evict;
            m_evicted_page_reg <= evict ? last_page : '0;
            m_page_number_reg  <= in_page_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_evicted      = m_evicted_reg;
    assign m_evicted_page = m_evicted_page_reg;
    assign m_page_number  = m_page_number_reg;

    // A page is resident in at most one frame in use.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> $onehot0(match_vec))
        else $error("page found in more than one frame");

    // Occupied frames stay packed at the front of the row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_vec >> 1) & ~valid_vec) == '0)
        else $error("frame list lost its packed order");

    // A hit never evicts, and without an eviction the evicted page is zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_hit_reg && m_evicted_reg))
        else $error("hit reported together with an eviction");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_evicted_reg) |-> (m_evicted_page_reg == '0))
        else $error("evicted page nonzero without an eviction");

    // A resolving item shows in the output register in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid_reg)
        else $error("resolved item did not reach the output register");

endmodule

@@ rtl/pgrep_cell.sv @@
// One frame of the ordered page list: holds a page and its valid bit.
// Depends on pgrep_pkg; instantiated in a row by page_replacement_fifo_lru_top.
`timescale 1ns / 1ps

module pgrep_cell
    import pgrep_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  logic       hit_in,
    input  page_t      cmp_page,
    input  page_t      left_page,
    input  logic       left_valid,
    input  logic       match_right,
    output logic       match,
    output logic       match_ge,
    output page_t      page,
    output logic       valid
);

    page_t page_reg;
    page_t page_next;
    logic  valid_reg;
    logic  valid_next;
    logic  shift;

    assign match    = valid_reg && ctrl.in_lim && (page_reg == cmp_page);
    assign match_ge = match || match_right;

    // On a miss every frame in use moves back one place. On an LRU hit only
    // the frames up to the hit position move, which lifts the hit page to the front.
    assign shift = hit_in ? (ctrl.lru && match_ge) : ctrl.in_lim;

    always_comb begin
        page_next  = page_reg;
        valid_next = valid_reg;
        if (ctrl.step) begin
            if (!ctrl.in_lim) begin
                valid_next = 1'b0;
            end else if (shift) begin
                page_next  = left_page;
                valid_next = left_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        page_reg <= page_next;
    end

    assign page  = page_reg;
    assign valid = valid_reg;

endmodule

@@ test/tb.sv @@
// Self-checking testbench for page_replacement_fifo_lru_top: a directed table, then
// random address traces over many policy and frame-count settings.
// Depends on pgrep_pkg and the RTL of the page replacement block.
`timescale 1ns / 1ps

module tb;
    import pgrep_pkg::*;

    localparam int NUM_FRAMES     = FRAMES_DEFAULT;
    localparam int NUM_DIR        = 26;
    localparam int NUM_PHASES     = 14;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int MAX_POOL       = NUM_FRAMES + 4;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 10;

    // One result item as the block reports it.
    typedef struct packed {
        logic  hit;
        logic  evicted;
        page_t evicted_page;
        page_t page_number;
    } access_result_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    // One row of the directed table. For a register row, value holds the write
    // data; for an item row it holds the address. When typed is set, the row
    // carries its own expected hit, evicted and evicted_page.
    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [ADDR_W-1:0]    value;
        logic                 typed;
        logic                 hit;
        logic                 evicted;
        page_t                evicted_page;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [ADDR_W-1:0]     s_virtual_address;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_hit;
    logic                  m_evicted;
    logic [PAGE_W-1:0]     m_evicted_page;
    logic [PAGE_W-1:0]     m_page_number;

    page_replacement_fifo_lru_top i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_virtual_address (s_virtual_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_hit             (m_hit),
        .m_evicted         (m_evicted),
        .m_evicted_page    (m_evicted_page),
        .m_page_number     (m_page_number)
    );

    // Shadow copy of the frame list, newest page at slot 0, and of the
    // configuration registers.
    page_t            frame_page [NUM_FRAMES];
    logic             frame_used [NUM_FRAMES];
    logic             lru_mode;
    logic [FIU_W-1:0] frames_reg;

    access_result_t pending_results [$];
    dir_row_t       dir_rows [NUM_DIR];
    int             mismatches = 0;

    // Shared pacing controls. When steady is set neither side idles; a nonzero
    // rx_hold_cycles makes the receiver hold off once for that many cycles.
    logic steady = 1'b0;
    int   rx_hold_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard limit on the run, set far beyond the slowest legal run.
    initial begin
        #4ms;
        $display("page_replacement_fifo_lru_top regression: fail");
        $finish;
    end

    // Clamps the frame count the way the block does: zero acts as one and
    // anything above the number of frames acts as the number of frames.
    function automatic int frame_limit(input logic [FIU_W-1:0] count);
        int lim;
        lim = int'(count);
        if (lim < 1)
            lim = 1;
        if (lim > NUM_FRAMES)
            lim = NUM_FRAMES;
        return lim;
    endfunction

    // Resolves one access against the shadow frame list and updates it.
    task automatic resolve_access(input logic [ADDR_W-1:0] addr, output access_result_t res);
        int    lim;
        int    pos;
        page_t pg;
        lim = frame_limit(frames_reg);
        pg  = page_t'(addr >> PAGE_SHIFT);
        pos = -1;
        res = '0;
        res.page_number = pg;
        // Frames beyond a lowered count are emptied silently.
        for (int i = lim; i < NUM_FRAMES; i++)
            frame_used[i] = 1'b0;
        for (int i = 0; i < lim; i++) begin
            if (pos < 0 && frame_used[i] && frame_page[i] == pg)
                pos = i;
        end
        if (pos >= 0) begin
            res.hit = 1'b1;
            // Only LRU reorders on a hit; FIFO leaves the list alone.
            if (lru_mode == MODE_LRU) begin
                for (int i = pos; i > 0; i--)
                    frame_page[i] = frame_page[i-1];
                frame_page[0] = pg;
            end
        end else begin
            if (frame_used[lim-1]) begin
                res.evicted      = 1'b1;
                res.evicted_page = frame_page[lim-1];
            end
            for (int i = lim - 1; i > 0; i--) begin
                frame_page[i] = frame_page[i-1];
                frame_used[i] = frame_used[i-1];
            end
            frame_page[0] = pg;
            frame_used[0] = 1'b1;
        end
    endtask

    // Lowers valid and waits until every expected result has come back.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Writes one configuration register once the block has drained.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_REPLACE_MODE)
            lru_mode = val[0];
        else
            frames_reg = val[FIU_W-1:0];
    endtask

    // Offers one address after a random gap (none when steady) and records its
    // expected result once taken. A typed row overrides the prediction.
    task automatic send_access(input logic [ADDR_W-1:0] addr, input logic use_typed,
                               input access_result_t typed_res);
        int             gap;
        access_result_t res;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_virtual_address <= addr;
        do
            @(posedge aclk);
        while (s_ready !== 1'b1);
        resolve_access(addr, res);
        if (use_typed)
            res = typed_res;
        pending_results.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [PAGE_W-1:0] want,
                               input logic [PAGE_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Result side: draws a stall before each item, then takes whatever the
    // block presents and compares it with the oldest expectation.
    initial begin
        int             stall;
        access_result_t want;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = steady ? 0 : $urandom_range(0, 6);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do
                @(posedge aclk);
            while (m_valid !== 1'b1);
            if (pending_results.size() == 0) begin
                $error("result item with no access pending: page %0h", m_page_number);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("hit", PAGE_W'(want.hit), PAGE_W'(m_hit));
                check_field("evicted", PAGE_W'(want.evicted), PAGE_W'(m_evicted));
                check_field("evicted_page", want.evicted_page, m_evicted_page);
                check_field("page_number", want.page_number, m_page_number);
            end
        end
    end

    // Stimulus: reset, the directed table, then the random phases.
    initial begin
        access_result_t    typed_res;
        page_t             pool [MAX_POOL];
        int                pool_size;
        logic [ADDR_W-1:0] addr;
        logic              mode;
        logic [FIU_W-1:0]  count;

        aresetn           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_REPLACE_MODE;
        cfg_wdata         <= '0;
        s_valid           <= 1'b0;
        s_virtual_address <= '0;

        for (int i = 0; i < NUM_FRAMES; i++) begin
            frame_page[i] = '0;
            frame_used[i] = 1'b0;
        end
        lru_mode   = MODE_FIFO;
        frames_reg = FIU_RESET;

        // The table starts from reset: FIFO with all sixteen frames. The
        // shrink to one frame checks that page 0 is dropped without being
        // reported while the newest page is the one evicted; zero and values
        // above the frame count check the clamping; the short three-frame runs
        // show LRU moving a hit forward and FIFO leaving it in place.
        dir_rows = '{
            '{ROW_ITEM, REG_REPLACE_MODE,  31'h0000_0000, 1'b1, 1'b0, 1'b0, 19'h00000},
            '{ROW_ITEM, REG_REPLACE_MODE,  31'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 19'h00000},
            '{ROW_ITEM, REG_REPLACE_MODE,  31'h0000_0FFF, 1'b1, 1'b1, 1'b0, 19'h00000},
            '{ROW_REG,  REG_FRAMES_IN_USE, 31'd1,         1'b0, 1'b0, 1'b0, 19'h00000},
            '{ROW_ITEM, REG_REPLACE_MODE,  31'h0000_1000, 1'b1, 1'b0, 1'b1, 19'h7FFFF},
            '{ROW_ITEM, REG_REPLACE_MODE,  31'h0000_0000, 1'b1, 1'b0, 1'b1, 19'h00001},
            '{ROW_REG,  REG_FRAMES_IN_USE, 31'd0,         1'b0, 1'b0, 1'b0, 19'h00000},
            '{ROW_ITEM, REG_REPLACE_MODE,  31'h0000_2000, 1'b1, 1'b0, 1'b1, 19'h00000},
            '{ROW_REG,  REG_REPLACE_MODE,  31'(MODE_LRU), 1'b0, 1'b0, 1'b0, 19'h00000},
            '{ROW_REG,  REG_FRAMES_IN_USE, 31'd31,        1'b0, 1'b0, 1'b0, 19'h00000},
            '{ROW_ITEM, REG_REPLACE_MODE,  31'h0000_2ABC, 1'b1, 1'b1, 1'b0, 19'h00000},
            '{ROW_ITEM, REG_REPLACE_MODE,  31'h0000_3000, 1'b1, 1'b0, 1'b0, 19'h00000},
            '{ROW_ITEM, REG_REPLACE_MODE,  31'h0000_4000, 1'b1, 1'b0, 1'b0, 19'h00000},
            '{ROW_ITEM, REG_REPLACE_MODE,  31'h0000_2000, 1'b0, 1'b0, 1'b0, 19'h00000},
            '{ROW_REG,  REG_FRAMES_IN_USE, 31'd3,         1'b0, 1'b0, 1'b0, 19'h00000},
            '{ROW_ITEM, REG_REPLACE_MODE,  31'h0000_5000, 1'b0, 1'b0, 1'b0, 19'h00000},
            '{ROW_ITEM, REG_REPLACE_MODE,  31'h0000_4000, 1'b0, 1'b0, 1'b0, 19'h00000},
            '{ROW_ITEM, REG_REPLACE_MODE,  31'h0000_6000, 1'b0, 1'b0, 1'b0, 19'h00000},
            '{ROW_REG,  REG_REPLACE_MODE,  31'(MODE_FIFO), 1'b0, 1'b0, 1'b0, 19'h00000},
            '{ROW_ITEM, REG_REPLACE_MODE,  31'h0000_5FFF, 1'b0, 1'b0, 1'b0, 19'h00000},
            '{ROW_ITEM, REG_REPLACE_MODE,  31'h0000_7000, 1'b0, 1'b0, 1'b0, 19'h00000},
            '{ROW_REG,  REG_FRAMES_IN_USE, 31'd17,        1'b0, 1'b0, 1'b0, 19'h00000},
            '{ROW_ITEM, REG_REPLACE_MODE,  31'h7FFF_F000, 1'b0, 1'b0, 1'b0, 19'h00000},
            '{ROW_ITEM, REG_REPLACE_MODE,  31'h5555_5555, 1'b0, 1'b0, 1'b0, 19'h00000},
            '{ROW_ITEM, REG_REPLACE_MODE,  31'h2AAA_AAAA, 1'b0, 1'b0, 1'b0, 19'h00000},
            '{ROW_ITEM, REG_REPLACE_MODE,  31'h0000_6000, 1'b0, 1'b0, 1'b0, 19'h00000}
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < NUM_DIR; r++) begin
            if (dir_rows[r].kind == ROW_REG) begin
                write_reg(dir_rows[r].reg_idx, dir_rows[r].value[CFG_DATA_W-1:0]);
            end else begin
                typed_res.hit          = dir_rows[r].hit;
                typed_res.evicted      = dir_rows[r].evicted;
                typed_res.evicted_page = dir_rows[r].evicted_page;
                typed_res.page_number  = page_t'(dir_rows[r].value >> PAGE_SHIFT);
                send_access(dir_rows[r].value, dir_rows[r].typed, typed_res);
            end
        end

        // Random phases. The first few pin the extremes of both registers;
        // the rest draw them at random, mostly within the legal frame range.
        // The frame list carries over between phases, so a smaller count also
        // exercises the silent emptying of the frames beyond it.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin mode = MODE_FIFO; count = 5'd16; end
                1: begin mode = MODE_LRU;  count = 5'd16; end
                2: begin mode = MODE_LRU;  count = 5'd1;  end
                3: begin mode = MODE_FIFO; count = 5'd0;  end
                4: begin mode = MODE_LRU;  count = 5'd31; end
                5: begin mode = MODE_FIFO; count = 5'd17; end
                6: begin mode = MODE_LRU;  count = 5'd2;  end
                default: begin
                    mode  = 1'($urandom_range(0, 1));
                    count = ($urandom_range(0, 3) == 0) ? FIU_W'($urandom_range(0, 31))
                                                        : FIU_W'($urandom_range(1, 16));
                end
            endcase
            write_reg(REG_REPLACE_MODE, CFG_DATA_W'(mode));
            write_reg(REG_FRAMES_IN_USE, CFG_DATA_W'(count));

            // A working set as large as the frames in use or a little larger
            // gives a steady mix of hits, fills and evictions.
            pool_size = frame_limit(count) + $urandom_range(0, 4);
            for (int j = 0; j < pool_size; j++)
                pool[j] = page_t'($urandom());

            steady = (phase == 1) || ($urandom_range(0, 3) == 0);
            // In this phase the receiver stops for a long stretch while the
            // sender keeps offering, so the block fills up and stalls its input.
            if (phase == 3)
                rx_hold_cycles = LONG_HOLD;

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Halfway through one phase the sender stops until the block
                // has returned every result.
                if (phase == 5 && k == ITEMS_PER_PHASE / 2)
                    wait_quiet();
                if ($urandom_range(0, 9) < 8)
                    addr = {pool[$urandom_range(0, pool_size - 1)], 12'($urandom())};
                else
                    addr = ADDR_W'($urandom());
                send_access(addr, 1'b0, '0);
            end
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("page_replacement_fifo_lru_top regression: pass");
        else
            $display("page_replacement_fifo_lru_top regression: fail");
        $finish;
    end

endmodule
